### sv/tls_pkg.sv
// shared types and constants for the toeplitz levinson solver
package tls_pkg;

  localparam logic signed [31:0] QONE = 32'sh4000_0000;
  localparam logic [5:0] SIZE_RESET = 6'd32;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_QSUB,
    OP_SUBR,
    OP_ADDR,
    OP_ACC_FIRST,
    OP_ACC_ADD,
    OP_SUBACC,
    OP_DIV,
    OP_TQ,
    OP_WR_B,
    OP_WR_C,
    OP_WR_Y,
    OP_WR_E,
    OP_LD_V,
    OP_LD_G,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_CORR,
    SRC_RHS,
    SRC_B,
    SRC_C,
    SRC_Y,
    SRC_V,
    SRC_G,
    SRC_E,
    SRC_T
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t src_a;
    src_t src_b;
    logic last;
  } cmd_t;

endpackage

### sv/tls_div.sv
// iterative fixed point divider, (num * 2^30) / den, truncated and saturated
module tls_div import tls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t     state;
  logic [61:0] dvd;
  logic [31:0] dsr;
  logic [32:0] rem;
  logic [61:0] q;
  logic [5:0]  cnt;
  logic        neg;

  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem[31:0], dvd[61]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            if (den == 32'sd0) begin
              if (num > 32'sd0) quot <= 32'sh7FFF_FFFF;
              else if (num < 32'sd0) quot <= 32'sh8000_0000;
              else quot <= 32'sd0;
              done <= 1'b1;
            end else begin
              neg   <= num[31] ^ den[31];
              dvd   <= {(num[31] ? 32'(-num) : 32'(num)), 30'd0};
              dsr   <= den[31] ? 32'(-den) : 32'(den);
              rem   <= 33'd0;
              q     <= 62'd0;
              cnt   <= 6'd62;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
          q   <= {q[60:0], fits};
          dvd <= {dvd[60:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= D_FIN;
        end
        D_FIN: begin
          if (!neg) begin
            if (q > 62'h7FFF_FFFF) quot <= 32'sh7FFF_FFFF;
            else quot <= $signed(q[31:0]);
          end else begin
            if (q > 62'h8000_0000) quot <= 32'sh8000_0000;
            else quot <= $signed(32'(-q[31:0]));
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

### sv/tls_datapath.sv
// datapath: pair stores, recursion vectors, multiplier, accumulator and divider
module tls_datapath import tls_pkg::*; #(
  parameter int MAX_ORDER = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  input  logic [$clog2(MAX_ORDER)-1:0] addr_p,
  input  logic [$clog2(MAX_ORDER)-1:0] addr_q,
  input  logic [$clog2(MAX_ORDER)-1:0] w_addr,
  input  logic signed [31:0]           corr_value,
  input  logic signed [31:0]           rhs_value,
  output logic                         div_done,
  output logic                         result_valid,
  output logic signed [31:0]           solution_value,
  output logic signed [31:0]           error_value,
  output logic                         not_positive,
  output logic                         last_result
);

  logic signed [31:0] corr_mem [MAX_ORDER];
  logic signed [31:0] rhs_mem  [MAX_ORDER];
  logic signed [31:0] b_mem    [MAX_ORDER];
  logic signed [31:0] c_mem    [MAX_ORDER];
  logic signed [31:0] y_mem    [MAX_ORDER];
  logic signed [31:0] e_mem    [MAX_ORDER];

  logic signed [31:0] rd_corr, rd_rhs, rd_b, rd_c, rd_y, rd_e;
  logic signed [63:0] prod, acc;
  logic signed [31:0] t, v, g, eprev;
  logic               bad;

  logic signed [31:0] opa, opb, r_prod, r_acc, quot;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic signed [31:0] round30(input logic signed [63:0] a);
    logic signed [63:0] s;
    s = sadd64(a, 64'sh2000_0000);
    return sat32(s >>> 30);
  endfunction

  function automatic logic signed [31:0] pick(input src_t s, input logic signed [31:0] corr,
    input logic signed [31:0] rhs, input logic signed [31:0] bv, input logic signed [31:0] cv,
    input logic signed [31:0] yv, input logic signed [31:0] vv, input logic signed [31:0] gv,
    input logic signed [31:0] ev, input logic signed [31:0] tv);
    logic signed [31:0] r;
    unique case (s)
      SRC_ONE:  r = QONE;
      SRC_CORR: r = corr;
      SRC_RHS:  r = rhs;
      SRC_B:    r = bv;
      SRC_C:    r = cv;
      SRC_Y:    r = yv;
      SRC_V:    r = vv;
      SRC_G:    r = gv;
      SRC_E:    r = ev;
      SRC_T:    r = tv;
      default:  r = 32'sd0;
    endcase
    return r;
  endfunction

  assign opa    = pick(cmd.src_a, rd_corr, rd_rhs, rd_b, rd_c, rd_y, v, g, eprev, t);
  assign opb    = pick(cmd.src_b, rd_corr, rd_rhs, rd_b, rd_c, rd_y, v, g, eprev, t);
  assign r_prod = round30(prod);
  assign r_acc  = round30(acc);

  tls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV),
    .num   (t),
    .den   (eprev),
    .done  (div_done),
    .quot  (quot)
  );

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      corr_mem[w_addr] <= corr_value;
      rhs_mem[w_addr]  <= rhs_value;
    end
    if (cmd.op == OP_WR_B) b_mem[w_addr] <= t;
    if (cmd.op == OP_WR_C) c_mem[w_addr] <= t;
    if (cmd.op == OP_WR_Y) y_mem[w_addr] <= t;
    if (cmd.op == OP_WR_E) e_mem[w_addr] <= t;
    rd_corr <= corr_mem[addr_p];
    rd_c    <= c_mem[addr_p];
    rd_rhs  <= rhs_mem[addr_q];
    rd_b    <= b_mem[addr_q];
    rd_y    <= y_mem[addr_q];
    rd_e    <= e_mem[addr_q];
  end

  // arithmetic
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_MUL:       prod <= opa * opb;
      OP_QSUB:      t <= sat32(64'(QONE) - 64'(r_prod));
      OP_SUBR:      t <= sat32(64'(opa) - 64'(r_prod));
      OP_ADDR:      t <= sat32(64'(opa) + 64'(r_prod));
      OP_ACC_FIRST: acc <= prod;
      OP_ACC_ADD:   acc <= sadd64(acc, prod);
      OP_SUBACC:    t <= sat32(64'(opa) - 64'(r_acc));
      OP_TQ:        t <= quot;
      OP_LD_V:      v <= t;
      OP_LD_G:      g <= t;
      OP_WR_E: begin
        eprev <= t;
        bad   <= ((w_addr == '0) ? 1'b0 : bad) | (t <= 32'sd0);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.op == OP_EMIT;
    end
    if (cmd.op == OP_EMIT) begin
      solution_value <= rd_y;
      error_value    <= cmd.last ? 32'sd0 : rd_e;
      not_positive   <= bad;
      last_result    <= cmd.last;
    end
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !result_valid)
    else $error("result strobe after last result");

endmodule

### sv/tls_ctrl.sv
// controller: load counting, recursion sequencing and result emission
module tls_ctrl import tls_pkg::*; #(
  parameter int MAX_ORDER = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [5:0]                   system_size,
  input  logic                         div_done,
  output cmd_t                         cmd,
  output logic [$clog2(MAX_ORDER)-1:0] addr_p,
  output logic [$clog2(MAX_ORDER)-1:0] addr_q,
  output logic [$clog2(MAX_ORDER)-1:0] w_addr
);

  localparam int AW = $clog2(MAX_ORDER);
  localparam logic [6:0] MAXO = 7'(MAX_ORDER);

  typedef enum logic [4:0] {
    S_IDLE, S_E0, S_B0, S_B1, S_Y0N, S_Y1N, S_DWAIT, S_DSTORE, S_LOOP,
    S_FDOT, S_FNEG, S_FDIV, S_EV, S_EE, S_RDOT, S_LAM, S_COPY, S_BUPD,
    S_YUPD, S_EMIT
  } state_t;

  typedef enum logic [1:0] {DST_Y, DST_V, DST_G} dst_t;

  state_t        state, ret;
  dst_t          dst;
  logic [1:0]    ph;
  logic [AW-1:0] i, k, dst_idx, load_count;
  logic [5:0]    size;

  logic [AW-1:0] nm1, idx;

  always_comb begin
    if (size < 6'd2) nm1 = AW'(1);
    else if ({1'b0, size} > MAXO) nm1 = AW'(MAXO - 7'd1);
    else nm1 = AW'(size - 6'd1);
  end

  assign idx       = (load_count >= nm1) ? nm1 : load_count;
  assign busy      = state != S_IDLE;
  assign cfg_ready = state == S_IDLE;

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.src_a = SRC_ZERO;
    cmd.src_b = SRC_ZERO;
    cmd.last  = 1'b0;
    addr_p    = '0;
    addr_q    = '0;
    w_addr    = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          w_addr = idx;
        end
      end
      S_E0: begin
        addr_p = AW'(1);
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_CORR; cmd.src_b = SRC_CORR; end
          2'd2: cmd.op = OP_QSUB;
          2'd3: cmd.op = OP_WR_E;
          default: ;
        endcase
      end
      S_B0: begin
        addr_p = AW'(1);
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_CORR; cmd.src_b = SRC_ONE; end
          2'd2: cmd.op = OP_SUBR;
          2'd3: cmd.op = OP_WR_B;
          default: ;
        endcase
      end
      S_B1: begin
        w_addr = AW'(1);
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_ONE; cmd.src_b = SRC_ONE; end
          2'd2: cmd.op = OP_ADDR;
          2'd3: cmd.op = OP_WR_B;
          default: ;
        endcase
      end
      S_Y0N, S_Y1N: begin
        addr_p = AW'(1);
        addr_q = ((ph == 2'd0) == (state == S_Y0N)) ? AW'(1) : '0;
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_CORR; cmd.src_b = SRC_RHS; end
          2'd2: begin cmd.op = OP_SUBR; cmd.src_a = SRC_RHS; end
          2'd3: cmd.op = OP_DIV;
          default: ;
        endcase
      end
      S_DWAIT: if (div_done) cmd.op = OP_TQ;
      S_DSTORE: begin
        w_addr = dst_idx;
        unique case (dst)
          DST_Y:   cmd.op = OP_WR_Y;
          DST_V:   cmd.op = OP_LD_V;
          default: cmd.op = OP_LD_G;
        endcase
      end
      S_FDOT, S_RDOT: begin
        addr_p = (state == S_FDOT) ? (k + AW'(1)) : (i + AW'(1) - k);
        addr_q = k;
        unique case (ph)
          2'd1: begin
            cmd.op    = OP_MUL;
            cmd.src_a = SRC_CORR;
            cmd.src_b = (state == S_FDOT) ? SRC_B : SRC_Y;
          end
          2'd2: cmd.op = (k == '0) ? OP_ACC_FIRST : OP_ACC_ADD;
          default: ;
        endcase
      end
      S_FNEG: cmd.op = OP_SUBACC;
      S_FDIV: cmd.op = OP_DIV;
      S_EV: begin
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_V; cmd.src_b = SRC_V; end
          2'd2: cmd.op = OP_QSUB;
          default: ;
        endcase
      end
      S_EE: begin
        w_addr = i;
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_E; cmd.src_b = SRC_T; end
          2'd2: cmd.op = OP_ADDR;
          2'd3: cmd.op = OP_WR_E;
          default: ;
        endcase
      end
      S_LAM: begin
        addr_q = i + AW'(1);
        unique case (ph)
          2'd2: begin cmd.op = OP_SUBACC; cmd.src_a = SRC_RHS; end
          2'd3: cmd.op = OP_DIV;
          default: ;
        endcase
      end
      S_COPY: begin
        addr_q = k;
        w_addr = k;
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_B; cmd.src_b = SRC_ONE; end
          2'd2: cmd.op = OP_ADDR;
          2'd3: cmd.op = OP_WR_C;
          default: ;
        endcase
      end
      S_BUPD: begin
        addr_p = i - k;
        addr_q = k - AW'(1);
        w_addr = k;
        unique case (ph)
          2'd1: begin
            cmd.op    = OP_MUL;
            cmd.src_a = SRC_V;
            cmd.src_b = (k == i + AW'(1)) ? SRC_ZERO : SRC_C;
          end
          2'd2: begin cmd.op = OP_ADDR; cmd.src_a = (k == '0) ? SRC_ZERO : SRC_B; end
          2'd3: cmd.op = OP_WR_B;
          default: ;
        endcase
      end
      S_YUPD: begin
        addr_q = k;
        w_addr = k;
        unique case (ph)
          2'd1: begin cmd.op = OP_MUL; cmd.src_a = SRC_G; cmd.src_b = SRC_B; end
          2'd2: begin
            cmd.op    = OP_ADDR;
            cmd.src_a = (k == i + AW'(1)) ? SRC_ZERO : SRC_Y;
          end
          2'd3: cmd.op = OP_WR_Y;
          default: ;
        endcase
      end
      S_EMIT: begin
        addr_q = k;
        if (ph == 2'd1) begin
          cmd.op   = OP_EMIT;
          cmd.last = k == nm1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ph         <= 2'd0;
      load_count <= '0;
      size       <= SIZE_RESET;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) size <= system_size;
          if (start) begin
            ph <= 2'd0;
            if (idx < nm1) begin
              load_count <= idx + AW'(1);
            end else begin
              load_count <= '0;
              state      <= S_E0;
            end
          end
        end
        S_E0, S_B0, S_B1, S_EV, S_EE: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            unique case (state)
              S_E0:    state <= S_B0;
              S_B0:    state <= S_B1;
              S_B1:    state <= S_Y0N;
              S_EV:    state <= S_EE;
              default: begin state <= S_RDOT; k <= '0; end
            endcase
          end
        end
        S_Y0N: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            state   <= S_DWAIT;
            ret     <= S_Y1N;
            dst     <= DST_Y;
            dst_idx <= '0;
          end
        end
        S_Y1N: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            state   <= S_DWAIT;
            ret     <= S_LOOP;
            dst     <= DST_Y;
            dst_idx <= AW'(1);
            i       <= AW'(1);
          end
        end
        S_DWAIT: if (div_done) state <= S_DSTORE;
        S_DSTORE: begin
          state <= ret;
          ph    <= 2'd0;
          k     <= '0;
        end
        S_LOOP: begin
          ph <= 2'd0;
          k  <= '0;
          state <= (i == nm1) ? S_EMIT : S_FDOT;
        end
        S_FDOT: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (k == i) state <= S_FNEG;
            else k <= k + AW'(1);
          end
        end
        S_FNEG: state <= S_FDIV;
        S_FDIV: begin
          state <= S_DWAIT;
          ret   <= S_EV;
          dst   <= DST_V;
        end
        S_RDOT: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (k == i) state <= S_LAM;
            else k <= k + AW'(1);
          end
        end
        S_LAM: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            state <= S_DWAIT;
            ret   <= S_COPY;
            dst   <= DST_G;
          end
        end
        S_COPY: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (k == i) begin
              state <= S_BUPD;
              k     <= i + AW'(1);
            end else begin
              k <= k + AW'(1);
            end
          end
        end
        S_BUPD: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (k == '0) state <= S_YUPD;
            else k <= k - AW'(1);
          end
        end
        S_YUPD: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (k == i + AW'(1)) begin
              state <= S_LOOP;
              i     <= i + AW'(1);
            end else begin
              k <= k + AW'(1);
            end
          end
        end
        S_EMIT: begin
          if (ph == 2'd1) begin
            ph <= 2'd0;
            if (k == nm1) state <= S_IDLE;
            else k <= k + AW'(1);
          end else begin
            ph <= 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV |=> state == S_DWAIT)
    else $error("division issued without waiting");

  a_fdot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FDOT || state == S_RDOT || state == S_COPY) |-> k <= i)
    else $error("dot product index past order");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> k <= nm1)
    else $error("result index past system size");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_LOAD |-> !busy)
    else $error("pair stored while solving");

endmodule

### sv/toeplitz_levinson_solver.sv
// top level of the symmetric toeplitz solver
//
// start with corr_value/rhs_value transfers one pair (r[k], x[k]) when busy is
// low; pairs fill index 0 upward. system_size (cfg_valid/cfg_ready, ready when
// idle) sets n, clamped to 2..MAX_ORDER. r[0] is taken as one.
// the transfer of pair n-1 starts the solve: busy rises and stays high until
// the last result. results come one per index k = 0..n-1, each marked by a
// one-cycle result_valid strobe, last_result on k = n-1.
// the receiver cannot stall; results must be taken on the strobe.
// cost: one shared multiplier and a 62-step divider; the time a solve takes from
// the last pair to the last result is set by the order-squared passes over the
// vector memories and two divisions per order.
// every pair, the last one included, is accepted in the cycle in which start is high.
// reset clears the controller, the load count and sets n to 32; the vector
// memories are not cleared and only used after being written by a solve.
module toeplitz_levinson_solver import tls_pkg::*; #(
  parameter int MAX_ORDER = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] corr_value,
  input  logic signed [31:0] rhs_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         system_size,
  output logic               result_valid,
  output logic signed [31:0] solution_value,
  output logic signed [31:0] error_value,
  output logic               not_positive,
  output logic               last_result
);

  cmd_t                         cmd;
  logic [$clog2(MAX_ORDER)-1:0] addr_p, addr_q, w_addr;
  logic                         div_done;

  tls_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .system_size (system_size),
    .div_done    (div_done),
    .cmd         (cmd),
    .addr_p      (addr_p),
    .addr_q      (addr_q),
    .w_addr      (w_addr)
  );

  tls_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .addr_p         (addr_p),
    .addr_q         (addr_q),
    .w_addr         (w_addr),
    .corr_value     (corr_value),
    .rhs_value      (rhs_value),
    .div_done       (div_done),
    .result_valid   (result_valid),
    .solution_value (solution_value),
    .error_value    (error_value),
    .not_positive   (not_positive),
    .last_result    (last_result)
  );

endmodule
